### rtl/stsf_pkg.sv
// Shared types and constants of the scanline triangle span fill block.
package stsf_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COLOUR_BITS = 32;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BOTTOM,
    PH_TOP,
    PH_FLAT
  } phase_t;

  typedef enum logic [1:0] {
    SEG_BOT,
    SEG_TOP_FT,
    SEG_TOP_MID
  } seg_t;

  typedef enum logic [1:0] {
    DIV_SPLIT,
    DIV_LEFT,
    DIV_RIGHT
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_CLASSIFY,
    ST_MUL,
    ST_SPLIT_START,
    ST_SPLIT_WAIT,
    ST_LEFT_START,
    ST_LEFT_WAIT,
    ST_RIGHT_START,
    ST_RIGHT_WAIT,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic     capture;
    logic     sort;
    logic     set_flat;
    logic     x4_from_x3;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     store_x4;
    logic     store_left;
    logic     store_right;
    logic     enter;
    logic     request;
    seg_t     seg;
  } dp_cmd_t;

  typedef struct packed {
    logic flat;
    logic flat_top;
    logic flat_bot;
    logic need_mid;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/stsf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, signed result.
module stsf_div #(
  parameter int DW = 29,
  parameter int DVW = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DW-1:0]        dividend,
  input  logic [DVW-1:0]       divisor,
  input  logic                 neg,
  output logic                 busy,
  output logic signed [DW:0]   quotient
);
  localparam int CW = $clog2(DW + 1);

  logic [DVW-1:0] rem;
  logic [DW-1:0]  quo;
  logic [DVW-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic           neg_r;
  logic [DVW:0]   shifted;
  logic [DVW+1:0] trial;
  logic           qbit;

  always_comb begin
    shifted = {rem, quo[DW-1]};
    trial = {1'b0, shifted} - {2'b00, dvs};
    qbit = ~trial[DVW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(DW);
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
      neg_r <= neg;
    end else if (busy) begin
      rem <= qbit ? trial[DVW-1:0] : shifted[DVW-1:0];
      quo <= {quo[DW-2:0], qbit};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

### rtl/stsf_ctrl.sv
// Controller state machine sequencing loads, slope divisions and span requests.
module stsf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               mode,
  input  stsf_pkg::dp_stat_t stat,
  output logic               in_stall,
  output stsf_pkg::dp_cmd_t  cmd
);
  import stsf_pkg::*;

  ctrl_state_t state, state_next;
  seg_t        seg, seg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seg <= SEG_BOT;
    end else begin
      state <= state_next;
      seg <= seg_next;
    end
  end

  always_comb begin
    state_next = state;
    seg_next = seg;
    in_stall = 1'b1;
    cmd = '0;
    cmd.div_sel = DIV_LEFT;
    cmd.seg = seg;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!mode) begin
            cmd.capture = 1'b1;
            state_next = ST_SORT;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SORT: begin
        cmd.sort = 1'b1;
        state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (stat.flat) begin
          cmd.set_flat = 1'b1;
          state_next = ST_IDLE;
        end else if (stat.flat_top) begin
          seg_next = SEG_TOP_FT;
          state_next = ST_LEFT_START;
        end else if (stat.flat_bot) begin
          cmd.x4_from_x3 = 1'b1;
          seg_next = SEG_BOT;
          state_next = ST_LEFT_START;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_SPLIT_START;
      end
      ST_SPLIT_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_SPLIT;
        state_next = ST_SPLIT_WAIT;
      end
      ST_SPLIT_WAIT: begin
        if (!stat.div_busy) begin
          cmd.store_x4 = 1'b1;
          seg_next = SEG_BOT;
          state_next = ST_LEFT_START;
        end
      end
      ST_LEFT_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_LEFT;
        state_next = ST_LEFT_WAIT;
      end
      ST_LEFT_WAIT: begin
        if (!stat.div_busy) begin
          cmd.store_left = 1'b1;
          state_next = ST_RIGHT_START;
        end
      end
      ST_RIGHT_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_RIGHT;
        state_next = ST_RIGHT_WAIT;
      end
      ST_RIGHT_WAIT: begin
        if (!stat.div_busy) begin
          cmd.store_right = 1'b1;
          cmd.enter = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.request = 1'b1;
          // Leaving the bottom part needs fresh slopes for the top part.
          if (stat.need_mid) begin
            seg_next = SEG_TOP_MID;
            state_next = ST_LEFT_START;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/stsf_datapath.sv
// Datapath: vertex sort, split point, edge slopes, edge walk and span output register.
module stsf_datapath #(
  parameter int COORD_BITS = stsf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = stsf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  stsf_pkg::dp_cmd_t                    cmd,
  output stsf_pkg::dp_stat_t                   stat,
  input  logic signed [COORD_BITS-1:0]         vert_a_x,
  input  logic signed [COORD_BITS-1:0]         vert_a_y,
  input  logic signed [COORD_BITS-1:0]         vert_b_x,
  input  logic signed [COORD_BITS-1:0]         vert_b_y,
  input  logic signed [COORD_BITS-1:0]         vert_c_x,
  input  logic signed [COORD_BITS-1:0]         vert_c_y,
  input  logic [stsf_pkg::COLOUR_BITS-1:0]     fill_colour,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [COORD_BITS-1:0]         span_y,
  output logic signed [COORD_BITS-1:0]         span_x_left,
  output logic signed [COORD_BITS-1:0]         span_x_right,
  output logic [stsf_pkg::COLOUR_BITS-1:0]     span_colour,
  output logic                                 last_span,
  output logic                                 status
);
  import stsf_pkg::*;

  localparam int C = COORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int AW = C + F + 2;
  localparam int QW = C + 2;
  localparam int PW = 2 * C + 2;
  localparam int NW = 2 * C + 3;
  localparam int DW = ((C + F + 1) > NW) ? (C + F + 1) : NW;
  localparam int DVW = C + 1;

  logic signed [C-1:0]  raw_x [3];
  logic signed [C-1:0]  raw_y [3];
  logic signed [C-1:0]  sx [3];
  logic signed [C-1:0]  sy [3];
  logic signed [C-1:0]  tx [3];
  logic signed [C-1:0]  ty [3];
  logic signed [C-1:0]  sw_x, sw_y;
  logic [COLOUR_BITS-1:0] held_colour;
  logic signed [AW-1:0] lstep, rstep, lacc, racc;
  logic signed [C-1:0]  row, x4;
  phase_t               phase;
  logic signed [PW-1:0] prod_a, prod_b;

  logic signed [C:0]    x1e, x2e, x3e, x4e, y1e, y2e, y3e, rowe, d13;
  logic signed [C:0]    dxl, dxr, dyv, dx_sel;
  logic [C:0]           dx_mag;
  logic signed [NW-1:0] num;
  logic [NW-1:0]        num_mag;
  logic [DW-1:0]        div_dividend;
  logic [DVW-1:0]       div_divisor;
  logic                 div_neg;
  logic                 div_busy;
  logic signed [DW:0]   quotient;

  logic signed [QW-1:0] lq, rq, qmin, qmax;
  logic signed [C-1:0]  fmin, fmax;
  logic signed [C-1:0]  xl_out, xr_out;
  logic                 last_now;
  logic                 at_mid;
  logic                 out_free;

  function automatic logic signed [QW-1:0] trunc_fix(input logic signed [AW-1:0] v);
    logic adj;
    adj = v[AW-1] & (|v[F-1:0]);
    return $signed(v[AW-1:F]) + $signed({{(QW-1){1'b0}}, adj});
  endfunction

  function automatic logic signed [C-1:0] sat_coord(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] hi;
    logic signed [QW-1:0] lo;
    hi = $signed({3'b000, {(C-1){1'b1}}});
    lo = $signed({3'b111, {(C-1){1'b0}}});
    if (v > hi) begin
      return hi[C-1:0];
    end else if (v < lo) begin
      return lo[C-1:0];
    end else begin
      return v[C-1:0];
    end
  endfunction

  // Three compare-and-swap steps; a swap only on strictly greater y.
  always_comb begin
    tx = raw_x;
    ty = raw_y;
    sw_x = '0;
    sw_y = '0;
    if (ty[0] > ty[1]) begin
      sw_x = tx[0]; sw_y = ty[0];
      tx[0] = tx[1]; ty[0] = ty[1];
      tx[1] = sw_x; ty[1] = sw_y;
    end
    if (ty[1] > ty[2]) begin
      sw_x = tx[1]; sw_y = ty[1];
      tx[1] = tx[2]; ty[1] = ty[2];
      tx[2] = sw_x; ty[2] = sw_y;
    end
    if (ty[0] > ty[1]) begin
      sw_x = tx[0]; sw_y = ty[0];
      tx[0] = tx[1]; ty[0] = ty[1];
      tx[1] = sw_x; ty[1] = sw_y;
    end
  end

  always_comb begin
    x1e = {sx[0][C-1], sx[0]};
    x2e = {sx[1][C-1], sx[1]};
    x3e = {sx[2][C-1], sx[2]};
    x4e = {x4[C-1], x4};
    y1e = {sy[0][C-1], sy[0]};
    y2e = {sy[1][C-1], sy[1]};
    y3e = {sy[2][C-1], sy[2]};
    rowe = {row[C-1], row};
    d13 = y3e - y1e;
    case (cmd.seg)
      SEG_BOT: begin
        dxl = x2e - x1e;
        dxr = x4e - x1e;
        dyv = y2e - y1e;
      end
      SEG_TOP_FT: begin
        dxl = x3e - x1e;
        dxr = x3e - x2e;
        dyv = y3e - y1e;
      end
      SEG_TOP_MID: begin
        dxl = x3e - x2e;
        dxr = x3e - x4e;
        dyv = y3e - y2e;
      end
      default: begin
        dxl = '0;
        dxr = '0;
        dyv = '0;
      end
    endcase
    dx_sel = (cmd.div_sel == DIV_RIGHT) ? dxr : dxl;
    dx_mag = dx_sel[C] ? $unsigned(-dx_sel) : $unsigned(dx_sel);
    num = {prod_a[PW-1], prod_a} + {prod_b[PW-1], prod_b};
    num_mag = num[NW-1] ? $unsigned(-num) : $unsigned(num);
    if (cmd.div_sel == DIV_SPLIT) begin
      div_dividend = {{(DW-NW){1'b0}}, num_mag};
      div_divisor = $unsigned(d13);
      div_neg = num[NW-1];
    end else begin
      div_dividend = {{(DW-C-1){1'b0}}, dx_mag} << F;
      div_divisor = $unsigned(dyv);
      div_neg = dx_sel[C];
    end
  end

  stsf_div #(
    .DW (DW),
    .DVW(DVW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .neg     (div_neg),
    .busy    (div_busy),
    .quotient(quotient)
  );

  // Span ends for the current row.
  always_comb begin
    lq = trunc_fix(lacc);
    rq = trunc_fix(racc);
    if (lq > rq) begin
      qmin = rq;
      qmax = lq;
    end else begin
      qmin = lq;
      qmax = rq;
    end
    fmin = sx[0];
    fmax = sx[0];
    if (sx[1] < fmin) fmin = sx[1];
    if (sx[1] > fmax) fmax = sx[1];
    if (sx[2] < fmin) fmin = sx[2];
    if (sx[2] > fmax) fmax = sx[2];
    case (phase)
      PH_FLAT: begin
        xl_out = fmin;
        xr_out = fmax;
        last_now = 1'b1;
      end
      PH_BOTTOM: begin
        xl_out = sat_coord(qmin);
        xr_out = sat_coord(qmax);
        last_now = (row == sy[1]) && (sy[1] == sy[2]);
      end
      PH_TOP: begin
        xl_out = sat_coord(qmin);
        xr_out = sat_coord(qmax);
        last_now = rowe <= y2e + 1;
      end
      default: begin
        xl_out = '0;
        xr_out = '0;
        last_now = 1'b0;
      end
    endcase
    at_mid = row >= sy[1];
    out_free = !out_valid || !out_stall;
  end

  always_comb begin
    stat.flat = sy[0] == sy[2];
    stat.flat_top = sy[0] == sy[1];
    stat.flat_bot = sy[1] == sy[2];
    stat.need_mid = (phase == PH_BOTTOM) && at_mid && (sy[2] > sy[1]);
    stat.div_busy = div_busy;
    stat.out_free = out_free;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_x[0] <= vert_a_x;
      raw_y[0] <= vert_a_y;
      raw_x[1] <= vert_b_x;
      raw_y[1] <= vert_b_y;
      raw_x[2] <= vert_c_x;
      raw_y[2] <= vert_c_y;
      held_colour <= fill_colour;
    end
    if (cmd.sort) begin
      sx <= tx;
      sy <= ty;
    end
    if (cmd.mul) begin
      prod_a <= PW'(x1e) * PW'(d13);
      prod_b <= PW'(y2e - y1e) * PW'(x3e - x1e);
    end
    if (cmd.x4_from_x3) begin
      x4 <= sx[2];
    end
    if (cmd.store_x4) begin
      x4 <= quotient[C-1:0];
    end
    if (cmd.store_left) begin
      lstep <= quotient[AW-1:0];
    end
    if (cmd.store_right) begin
      rstep <= quotient[AW-1:0];
    end
    if (cmd.set_flat) begin
      row <= sy[0];
    end
    if (cmd.enter) begin
      if (cmd.seg == SEG_BOT) begin
        lacc <= {{2{sx[0][C-1]}}, sx[0], {F{1'b0}}};
        racc <= {{2{sx[0][C-1]}}, sx[0], {F{1'b0}}};
        row <= sy[0];
      end else begin
        lacc <= {{2{sx[2][C-1]}}, sx[2], {F{1'b0}}};
        racc <= {{2{sx[2][C-1]}}, sx[2], {F{1'b0}}};
        row <= sy[2];
      end
    end
    if (cmd.request) begin
      if (phase == PH_BOTTOM && !at_mid) begin
        row <= row + 1'b1;
        lacc <= lacc + lstep;
        racc <= racc + rstep;
      end else if (phase == PH_TOP && !last_now) begin
        row <= row - 1'b1;
        lacc <= lacc - lstep;
        racc <= racc - rstep;
      end
      if (phase == PH_IDLE) begin
        span_y <= '0;
        span_x_left <= '0;
        span_x_right <= '0;
        span_colour <= '0;
        last_span <= 1'b0;
        status <= 1'b1;
      end else begin
        span_y <= row;
        span_x_left <= xl_out;
        span_x_right <= xr_out;
        span_colour <= held_colour;
        last_span <= last_now;
        status <= 1'b0;
      end
    end
  end

  // Control registers: walk phase and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.set_flat) begin
        phase <= PH_FLAT;
      end else if (cmd.enter) begin
        phase <= (cmd.seg == SEG_BOT) ? PH_BOTTOM : PH_TOP;
      end else if (cmd.request) begin
        case (phase)
          PH_FLAT: phase <= PH_IDLE;
          PH_BOTTOM: begin
            if (at_mid && !(sy[2] > sy[1])) begin
              phase <= PH_IDLE;
            end
          end
          PH_TOP: begin
            if (last_now) begin
              phase <= PH_IDLE;
            end
          end
          default: phase <= PH_IDLE;
        endcase
      end
      if (cmd.request) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/scanline_triangle_span_fill.sv
// Top level of the scanline triangle span fill block.
//
// Input channel (in_valid / in_stall): an item with mode 0 loads a triangle
// (three vertices and a colour) and gives no result; an item with mode 1
// requests the next span and gives exactly one result item.
// Output channel (out_valid / out_stall): span row, left and right x, colour,
// last-span flag and a status bit that is 1 when no span was pending.
// One item is worked on at a time. A span request moves the controller to its
// emit state, which waits until the output register is free and then registers
// the result. A general load runs the bit-serial divider (dividend width
// DW = max(COORD_BITS + FRAC_BITS + 1, 2 * COORD_BITS + 3)) to form the
// split point and both edge slopes (fewer divisions when two rows are equal);
// the request that ends the bottom part also reloads both slopes. While the
// receiver stalls, the result holds in the output register and the next item
// may still be accepted; a request then waits until the register frees.
// Reset empties the output register and leaves no triangle loaded.
module scanline_triangle_span_fill #(
  parameter int COORD_BITS = stsf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = stsf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              mode,
  input  logic signed [COORD_BITS-1:0]      vert_a_x,
  input  logic signed [COORD_BITS-1:0]      vert_a_y,
  input  logic signed [COORD_BITS-1:0]      vert_b_x,
  input  logic signed [COORD_BITS-1:0]      vert_b_y,
  input  logic signed [COORD_BITS-1:0]      vert_c_x,
  input  logic signed [COORD_BITS-1:0]      vert_c_y,
  input  logic [stsf_pkg::COLOUR_BITS-1:0]  fill_colour,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      span_y,
  output logic signed [COORD_BITS-1:0]      span_x_left,
  output logic signed [COORD_BITS-1:0]      span_x_right,
  output logic [stsf_pkg::COLOUR_BITS-1:0]  span_colour,
  output logic                              last_span,
  output logic                              status
);
  import stsf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stsf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .mode    (mode),
    .stat    (stat),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  stsf_datapath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .vert_a_x    (vert_a_x),
    .vert_a_y    (vert_a_y),
    .vert_b_x    (vert_b_x),
    .vert_b_y    (vert_b_y),
    .vert_c_x    (vert_c_x),
    .vert_c_y    (vert_c_y),
    .fill_colour (fill_colour),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .span_y      (span_y),
    .span_x_left (span_x_left),
    .span_x_right(span_x_right),
    .span_colour (span_colour),
    .last_span   (last_span),
    .status      (status)
  );

endmodule

### tb/tb_scanline_triangle_span_fill.sv
// Self-checking testbench for the scanline triangle span fill block.
`timescale 1ns / 1ps

module tb_scanline_triangle_span_fill;
  import stsf_pkg::*;

  localparam int CB = 13;
  localparam int FB = 16;
  localparam int TOTAL_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic          mode;
    logic [CB-1:0] v[6];
    logic [31:0]   colour;
  } tri_item_t;

  typedef struct {
    logic [CB-1:0] y;
    logic [CB-1:0] xl;
    logic [CB-1:0] xr;
    logic [31:0]   colour;
    logic          last;
    logic          status;
  } span_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic mode = 0;
  logic [CB-1:0] vert_a_x = 0, vert_a_y = 0, vert_b_x = 0, vert_b_y = 0;
  logic [CB-1:0] vert_c_x = 0, vert_c_y = 0;
  logic [31:0] fill_colour = 0;
  logic out_stall = 0;
  logic in_stall, out_valid, last_span, status;
  logic [CB-1:0] span_y, span_x_left, span_x_right;
  logic [31:0] span_colour;

  scanline_triangle_span_fill DUT (.*);

  always #5 clk = ~clk;

  tri_item_t pending_items[$];
  span_t     expected_spans[$];
  int errors = 0;
  int sent = 0;
  int cycles = 0;
  logic took = 0;

  // Shadow of the block's triangle walker.
  longint sv_c[6];
  longint l_acc, r_acc, l_step, r_step, row;
  phase_t ph = PH_IDLE;
  logic [31:0] held_col = 0;

  function automatic longint edge_slope(longint dx, longint dy);
    longint mag, q;
    if (dy <= 0) return 0;
    mag = dx < 0 ? -dx : dx;
    q = (mag << FB) / dy;
    return dx < 0 ? -q : q;
  endfunction

  function automatic logic [CB-1:0] clamp_coord(longint v);
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return v[CB-1:0];
  endfunction

  function automatic longint split_point_x();
    longint d13;
    d13 = sv_c[5] - sv_c[1];
    if (d13 <= 0) return sv_c[0];
    return (sv_c[0] * d13 + (sv_c[3] - sv_c[1]) * (sv_c[4] - sv_c[0])) / d13;
  endfunction

  function automatic void start_top_part(longint xa, longint ya, longint xb);
    l_step = edge_slope(sv_c[4] - xa, sv_c[5] - ya);
    r_step = edge_slope(sv_c[4] - xb, sv_c[5] - ya);
    l_acc = sv_c[4] <<< FB;
    r_acc = sv_c[4] <<< FB;
    row = sv_c[5];
    ph = PH_TOP;
  endfunction

  function automatic void order_pair(int i, int j);
    longint tx, ty;
    if (sv_c[2*i+1] > sv_c[2*j+1]) begin
      tx = sv_c[2*i]; ty = sv_c[2*i+1];
      sv_c[2*i] = sv_c[2*j]; sv_c[2*i+1] = sv_c[2*j+1];
      sv_c[2*j] = tx; sv_c[2*j+1] = ty;
    end
  endfunction

  function automatic void predict_span(tri_item_t it);
    span_t s;
    longint xl, xr, t, x4;
    logic last;
    if (it.mode == 1'b0) begin
      for (int i = 0; i < 6; i++) sv_c[i] = longint'($signed(it.v[i]));
      held_col = it.colour;
      order_pair(0, 1);
      order_pair(1, 2);
      order_pair(0, 1);
      if (sv_c[1] == sv_c[5]) begin
        ph = PH_FLAT;
        row = sv_c[1];
      end else if (sv_c[1] == sv_c[3]) begin
        start_top_part(sv_c[0], sv_c[1], sv_c[2]);
      end else begin
        x4 = (sv_c[3] == sv_c[5]) ? sv_c[4] : split_point_x();
        l_step = edge_slope(sv_c[2] - sv_c[0], sv_c[3] - sv_c[1]);
        r_step = edge_slope(x4 - sv_c[0], sv_c[3] - sv_c[1]);
        l_acc = sv_c[0] <<< FB;
        r_acc = sv_c[0] <<< FB;
        row = sv_c[1];
        ph = PH_BOTTOM;
      end
      return;
    end
    s = '{default: '0};
    if (ph == PH_IDLE) begin
      s.status = 1'b1;
      expected_spans.push_back(s);
      return;
    end
    if (ph == PH_FLAT) begin
      xl = sv_c[0]; xr = sv_c[0];
      for (int i = 1; i < 3; i++) begin
        if (sv_c[2*i] < xl) xl = sv_c[2*i];
        if (sv_c[2*i] > xr) xr = sv_c[2*i];
      end
      last = 1'b1;
    end else begin
      xl = l_acc / (64'sd1 <<< FB);
      xr = r_acc / (64'sd1 <<< FB);
      if (xl > xr) begin t = xl; xl = xr; xr = t; end
      last = (ph == PH_BOTTOM) ? (row == sv_c[3] && sv_c[3] == sv_c[5])
                               : (row <= sv_c[3] + 1);
    end
    s.y = clamp_coord(row);
    s.xl = clamp_coord(xl);
    s.xr = clamp_coord(xr);
    s.colour = held_col;
    s.last = last;
    expected_spans.push_back(s);
    if (ph == PH_FLAT) begin
      ph = PH_IDLE;
    end else if (ph == PH_BOTTOM) begin
      if (row >= sv_c[3]) begin
        if (sv_c[5] > sv_c[3]) start_top_part(sv_c[2], sv_c[3], split_point_x());
        else ph = PH_IDLE;
      end else begin
        row++;
        l_acc += l_step;
        r_acc += r_step;
      end
    end else if (last) begin
      ph = PH_IDLE;
    end else begin
      row--;
      l_acc -= l_step;
      r_acc -= r_step;
    end
  endfunction

  function automatic void add_load(int ax, int ay, int bx, int by, int cx, int cy,
                                   logic [31:0] col);
    tri_item_t it;
    it.mode = 1'b0;
    it.v[0] = ax[CB-1:0]; it.v[1] = ay[CB-1:0];
    it.v[2] = bx[CB-1:0]; it.v[3] = by[CB-1:0];
    it.v[4] = cx[CB-1:0]; it.v[5] = cy[CB-1:0];
    it.colour = col;
    pending_items.push_back(it);
  endfunction

  function automatic void add_requests(int n);
    tri_item_t it;
    for (int i = 0; i < n; i++) begin
      it.mode = 1'b1;
      for (int k = 0; k < 6; k++) it.v[k] = CB'($urandom);
      it.colour = $urandom;
      pending_items.push_back(it);
    end
  endfunction

  function automatic int near_coord(int base, int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return v;
  endfunction

  // Stimulus: directed triangles first, then random well-formed sequences.
  initial begin
    int bx, by, ys, xs, ay, byy, cy, n;
    add_requests(1);
    add_load(-4096, 5, 4095, 5, 0, 5, 32'hFFFF_FFFF);   // all rows equal
    add_requests(2);
    add_load(-4096, -4096, 4095, -4096, 0, -4093, 32'h0); // flat top
    add_requests(4);
    add_load(0, 4090, -4096, 4095, 4095, 4095, 32'h1234_5678); // flat bottom
    add_requests(6);
    add_load(-10, 0, 30, 4, 7, 9, 32'hA5A5_5A5A);        // general split
    add_requests(3);
    add_load(4095, 4095, -4096, -4096, 4095, -4094, 32'h5A5A_A5A5); // replaces
    add_requests(2);
    while (pending_items.size() < TOTAL_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        bx = $signed(13'($urandom));
        by = $signed(13'($urandom));
        ys = ($urandom_range(0, 19) == 0) ? 120 : 12;
        xs = ($urandom_range(0, 9) == 0) ? 4095 : 60;
        ay = near_coord(by, ys);
        byy = ($urandom_range(0, 5) == 0) ? ay : near_coord(by, ys);
        cy = ($urandom_range(0, 5) == 0) ? byy : near_coord(by, ys);
        add_load(near_coord(bx, xs), ay, near_coord(bx, xs), byy,
                 near_coord(bx, xs), cy, $urandom);
        n = (ay > byy ? ay : byy);
        n = (n > cy ? n : cy) - (ay < byy ? (ay < cy ? ay : cy) : (byy < cy ? byy : cy)) + 1;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
        else n = n + $urandom_range(0, 1);
        add_requests(n);
      end else if ($urandom_range(0, 1) == 0) begin
        add_load($signed(13'($urandom)), $signed(13'($urandom)), $signed(13'($urandom)),
                 $signed(13'($urandom)), $signed(13'($urandom)),
                 $signed(13'($urandom)), $urandom);
        add_requests(0);
      end else begin
        add_requests($urandom_range(1, 3));
      end
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  int send_idle, recv_idle, hold_off = 0;
  logic pressure_done = 0;

  always_comb begin
    if (sent < TOTAL_ITEMS / 3) begin
      send_idle = 38; recv_idle = 73;
    end else if (sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle = 73; recv_idle = 38;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  end

  always @(posedge clk) took <= in_valid && !in_stall && !rst;

  always @(negedge clk) begin
    tri_item_t it;
    if (!rst && (!in_valid || took)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        it = pending_items.pop_front();
        mode <= it.mode;
        vert_a_x <= it.v[0]; vert_a_y <= it.v[1];
        vert_b_x <= it.v[2]; vert_b_y <= it.v[3];
        vert_c_x <= it.v[4]; vert_c_y <= it.v[5];
        fill_colour <= it.colour;
        in_valid <= 1'b1;
        sent <= sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls; one long hold-off lets the block back up onto its input.
  always @(negedge clk) begin
    if (!pressure_done && sent >= 300) begin
      pressure_done <= 1'b1;
      hold_off <= 400;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    span_t e;
    tri_item_t it;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && in_valid && !in_stall) begin
      it.mode = mode;
      it.v[0] = vert_a_x; it.v[1] = vert_a_y;
      it.v[2] = vert_b_x; it.v[3] = vert_b_y;
      it.v[4] = vert_c_x; it.v[5] = vert_c_y;
      it.colour = fill_colour;
      predict_span(it);
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected span y=%0d", $time, $signed(span_y));
        errors++;
      end else begin
        e = expected_spans.pop_front();
        if ({span_y, span_x_left, span_x_right, span_colour, last_span, status} !==
            {e.y, e.xl, e.xr, e.colour, e.last, e.status}) begin
          $display("%0t: span mismatch expected y=%0d xl=%0d xr=%0d col=%h last=%b st=%b",
                   $time, $signed(e.y), $signed(e.xl), $signed(e.xr), e.colour,
                   e.last, e.status);
          $display("%0t:                 actual y=%0d xl=%0d xr=%0d col=%h last=%b st=%b",
                   $time, $signed(span_y), $signed(span_x_left), $signed(span_x_right),
                   span_colour, last_span, status);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (!rst);
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_spans.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_spans.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
